// File: hw/rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared definitions for the keypad code lock
// Widths, register map, reset values, status codes and the structs that
// travel between the register block and the lock core.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Largest code the entry buffer can hold, in characters.
    localparam int MAX_CODE_LEN = 8;

    // Field widths.
    localparam int KEY_W    = 8;
    localparam int CNT_W    = 4;
    localparam int TRIAL_W  = 3;
    localparam int SEC_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CODE_W   = 64;

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 5;
    localparam int IDX_LSB = 3;

    // Enter key character.
    localparam logic [KEY_W-1:0] ENTER_KEY = 8'h63;

    // Item kinds.
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Failed trial counter saturates here.
    localparam logic [TRIAL_W-1:0] TRIALS_SAT = 3'd7;

    // Reset values of the configuration registers ("1234", 4, 3, 120).
    localparam logic [CODE_W-1:0]  CODE_WORD_RST       = 64'd875770417;
    localparam logic [CNT_W-1:0]   CODE_LENGTH_RST     = 4'd4;
    localparam logic [TRIAL_W-1:0] MAX_TRIALS_RST      = 3'd3;
    localparam logic [SEC_W-1:0]   LOCKOUT_SECONDS_RST = 8'd120;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_CODE_WORD,
        REG_CODE_LENGTH,
        REG_MAX_TRIALS,
        REG_LOCKOUT_SECONDS
    } reg_idx_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED,
        STATUS_DROPPED,
        STATUS_ACCEPTED,
        STATUS_REJECTED,
        STATUS_LOCKOUT,
        STATUS_IGNORED,
        STATUS_TICK
    } status_t;

    // Configuration seen by the core.
    typedef struct packed {
        logic [CODE_W-1:0]  code_word;
        logic [CNT_W-1:0]   code_length;
        logic [TRIAL_W-1:0] max_trials;
        logic [SEC_W-1:0]   lockout_seconds;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        status_t            status;
        logic               unlocked;
        logic               locked_out;
        logic [SEC_W-1:0]   seconds_left;
        logic [CNT_W-1:0]   keys_entered;
        logic [TRIAL_W-1:0] trials_used;
    } result_t;

endpackage

// File: hw/rtl/kcl_cfg_regs.sv
// ----------------------------------------------------------------------------
// kcl_cfg_regs: configuration register block
// APB-style slave holding the code word, code length, trial limit and
// lockout length. Zero wait states; reads return the stored values.
// ----------------------------------------------------------------------------
module kcl_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kcl_pkg::ADDR_W-1:0]  paddr,
    input  logic [kcl_pkg::DATA_W-1:0]  pwdata,
    output logic [kcl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output kcl_pkg::cfg_t               cfg
);

    kcl_pkg::cfg_t    cfg_reg;
    kcl_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    // Register select comes from the address bits above the 8-byte offset.
    assign reg_idx = kcl_pkg::reg_idx_t'(paddr[kcl_pkg::ADDR_W-1:kcl_pkg::IDX_LSB]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes; each register keeps only its own low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_word       <= kcl_pkg::CODE_WORD_RST;
            cfg_reg.code_length     <= kcl_pkg::CODE_LENGTH_RST;
            cfg_reg.max_trials      <= kcl_pkg::MAX_TRIALS_RST;
            cfg_reg.lockout_seconds <= kcl_pkg::LOCKOUT_SECONDS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                kcl_pkg::REG_CODE_WORD:
                    cfg_reg.code_word <= pwdata[kcl_pkg::CODE_W-1:0];
                kcl_pkg::REG_CODE_LENGTH:
                    cfg_reg.code_length <= pwdata[kcl_pkg::CNT_W-1:0];
                kcl_pkg::REG_MAX_TRIALS:
                    cfg_reg.max_trials <= pwdata[kcl_pkg::TRIAL_W-1:0];
                kcl_pkg::REG_LOCKOUT_SECONDS:
                    cfg_reg.lockout_seconds <= pwdata[kcl_pkg::SEC_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            kcl_pkg::REG_CODE_WORD:
                prdata = kcl_pkg::DATA_W'(cfg_reg.code_word);
            kcl_pkg::REG_CODE_LENGTH:
                prdata = kcl_pkg::DATA_W'(cfg_reg.code_length);
            kcl_pkg::REG_MAX_TRIALS:
                prdata = kcl_pkg::DATA_W'(cfg_reg.max_trials);
            kcl_pkg::REG_LOCKOUT_SECONDS:
                prdata = kcl_pkg::DATA_W'(cfg_reg.lockout_seconds);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: lock state and per-item update
// Input register, a single pass of update logic over the lock state, and
// a result register. The state advances when an item leaves the input
// register for the result register.
// ----------------------------------------------------------------------------
module kcl_core #(
    parameter int MaxCodeLen = kcl_pkg::MAX_CODE_LEN
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kcl_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [kcl_pkg::KEY_W-1:0]   key,
    output logic                        out_valid,
    input  logic                        out_stall,
    output kcl_pkg::result_t            result
);

    // Input stage.
    logic                        in_valid_reg;
    logic                        func_reg;
    logic [kcl_pkg::KEY_W-1:0]   key_reg;

    // Lock state.
    logic [kcl_pkg::KEY_W-1:0]   entry_buf_reg [MaxCodeLen];
    logic [kcl_pkg::CNT_W-1:0]   entry_count_reg;
    logic [kcl_pkg::CNT_W-1:0]   entry_count_next;
    logic                        entry_overflow_reg;
    logic                        entry_overflow_next;
    logic [kcl_pkg::TRIAL_W-1:0] failed_trials_reg;
    logic [kcl_pkg::TRIAL_W-1:0] failed_trials_next;
    logic [kcl_pkg::SEC_W-1:0]   lockout_reg;
    logic [kcl_pkg::SEC_W-1:0]   lockout_next;
    logic                        unlocked_reg;
    logic                        unlocked_next;

    // Result stage.
    logic                        out_valid_reg;
    kcl_pkg::result_t            result_reg;

    // Update logic.
    logic                        advance;
    logic                        accept;
    logic                        buf_we;
    logic                        mismatch;
    logic                        entry_match;
    logic [kcl_pkg::TRIAL_W-1:0] trials_inc;
    kcl_pkg::status_t            status_next;

    // An item moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            key_reg  <= key;
        end
    end

    // Compare the held characters with the code, one byte lane per slot.
    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < MaxCodeLen; i++)
        begin
            if ((kcl_pkg::CNT_W'(i) < entry_count_reg) &&
                (entry_buf_reg[i] != cfg.code_word[8*i +: 8]))
            begin
                mismatch = 1'b1;
            end
        end
    end

    assign entry_match = !entry_overflow_reg && !mismatch &&
                         (entry_count_reg == cfg.code_length);

    assign trials_inc = (failed_trials_reg == kcl_pkg::TRIALS_SAT) ?
                        failed_trials_reg : failed_trials_reg + 1'b1;

    // Next state for one item.
    always_comb
    begin
        entry_count_next    = entry_count_reg;
        entry_overflow_next = entry_overflow_reg;
        failed_trials_next  = failed_trials_reg;
        lockout_next        = lockout_reg;
        unlocked_next       = unlocked_reg;
        buf_we              = 1'b0;
        status_next         = kcl_pkg::STATUS_TICK;

        if (func_reg == kcl_pkg::FUNC_TICK)
        begin
            if (lockout_reg != '0)
            begin
                lockout_next = lockout_reg - 1'b1;
            end
            status_next = kcl_pkg::STATUS_TICK;
        end
        else if (unlocked_reg || (lockout_reg != '0))
        begin
            status_next = kcl_pkg::STATUS_IGNORED;
        end
        else if (key_reg == kcl_pkg::ENTER_KEY)
        begin
            if (entry_match)
            begin
                unlocked_next = 1'b1;
                status_next   = kcl_pkg::STATUS_ACCEPTED;
            end
            else if (trials_inc >= cfg.max_trials)
            begin
                failed_trials_next = '0;
                lockout_next       = cfg.lockout_seconds;
                status_next        = kcl_pkg::STATUS_LOCKOUT;
            end
            else
            begin
                failed_trials_next = trials_inc;
                status_next        = kcl_pkg::STATUS_REJECTED;
            end
            entry_count_next    = '0;
            entry_overflow_next = 1'b0;
        end
        else if (entry_count_reg < kcl_pkg::CNT_W'(MaxCodeLen))
        begin
            buf_we           = 1'b1;
            entry_count_next = entry_count_reg + 1'b1;
            status_next      = kcl_pkg::STATUS_STORED;
        end
        else
        begin
            entry_overflow_next = 1'b1;
            status_next         = kcl_pkg::STATUS_DROPPED;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            entry_overflow_reg <= 1'b0;
            failed_trials_reg  <= '0;
            lockout_reg        <= '0;
            unlocked_reg       <= 1'b0;
        end
        else if (advance)
        begin
            entry_count_reg    <= entry_count_next;
            entry_overflow_reg <= entry_overflow_next;
            failed_trials_reg  <= failed_trials_next;
            lockout_reg        <= lockout_next;
            unlocked_reg       <= unlocked_next;
        end
    end

    // Entry buffer: the slot at the current count takes the key.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxCodeLen; i++)
        begin
            if (advance && buf_we && (entry_count_reg == kcl_pkg::CNT_W'(i)))
            begin
                entry_buf_reg[i] <= key_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.status       <= status_next;
            result_reg.unlocked     <= unlocked_next;
            result_reg.locked_out   <= (lockout_next != '0);
            result_reg.seconds_left <= lockout_next;
            result_reg.keys_entered <= entry_count_next;
            result_reg.trials_used  <= failed_trials_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: hw/rtl/keypad_code_lock_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_top: keypad code lock with lockout
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_stall    func, key
//   out       source     out_valid/out_stall  status, unlocked, locked_out,
//                                             seconds_left, keys_entered,
//                                             trials_used
//   cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle is taken while in_stall is low; its result beat passes
// through the input register, then the result register.
// The result register decouples the sides: a new item is taken while a
// result waits, and input stalls only when both registers are full.
// Reset (rst_n low, asynchronous) clears the lock state and loads the
// default code "1234", length 4, three trials and a 120-tick lockout.
// ----------------------------------------------------------------------------
module keypad_code_lock_top #(
    parameter int MaxCodeLen = kcl_pkg::MAX_CODE_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [kcl_pkg::KEY_W-1:0]     key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kcl_pkg::STATUS_W-1:0]  status,
    output logic                          unlocked,
    output logic                          locked_out,
    output logic [kcl_pkg::SEC_W-1:0]     seconds_left,
    output logic [kcl_pkg::CNT_W-1:0]     keys_entered,
    output logic [kcl_pkg::TRIAL_W-1:0]   trials_used,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcl_pkg::ADDR_W-1:0]    paddr,
    input  logic [kcl_pkg::DATA_W-1:0]    pwdata,
    output logic [kcl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    kcl_pkg::cfg_t    cfg;
    kcl_pkg::result_t result;

    // Configuration registers.
    kcl_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Lock core.
    kcl_core #(
        .MaxCodeLen (MaxCodeLen)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Result beat onto the output ports.
    assign status       = result.status;
    assign unlocked     = result.unlocked;
    assign locked_out   = result.locked_out;
    assign seconds_left = result.seconds_left;
    assign keys_entered = result.keys_entered;
    assign trials_used  = result.trials_used;

endmodule

// File: hw/rtl/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks for the keypad code lock
// Watches the result channel and checks relations between the fields of
// each beat and across beats.
// ----------------------------------------------------------------------------
module kcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [kcl_pkg::STATUS_W-1:0]  status,
    input logic                          unlocked,
    input logic                          locked_out,
    input logic [kcl_pkg::SEC_W-1:0]     seconds_left,
    input logic [kcl_pkg::CNT_W-1:0]     keys_entered,
    input logic [kcl_pkg::TRIAL_W-1:0]   trials_used
);

    // A stalled result beat stays and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
            $stable(unlocked) && $stable(seconds_left) &&
            $stable(keys_entered) && $stable(trials_used))
    else $error("result beat changed while stalled");

    // The lockout flag follows the remaining lockout time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (locked_out == (seconds_left != '0)))
    else $error("locked_out disagrees with seconds_left");

    // An accepted code always reports the lock as open.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == kcl_pkg::STATUS_ACCEPTED) |-> unlocked)
    else $error("code accepted but lock not open");

    // Every enter that is not ignored clears the entry, and a lockout clears the trial count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == kcl_pkg::STATUS_ACCEPTED) ||
                      (status == kcl_pkg::STATUS_REJECTED) ||
                      (status == kcl_pkg::STATUS_LOCKOUT))
        |-> (keys_entered == '0) &&
            ((status != kcl_pkg::STATUS_LOCKOUT) || (trials_used == '0)))
    else $error("entry or trial count not cleared on enter");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);
